@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the fill engine checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define FBF_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define FBF_ASSERT_NXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hdl/fbf_pkg.sv @@
// ----------------------------------------------------------------------------
// Fill engine package
// Widths, codes, register layout and the command record shared by the
// front end, the command queue and the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fbf_pkg;

   // Default store size in pixel words.
   localparam int unsigned DEFAULT_STORE_WORDS = 65536;

   // Field widths.
   localparam int unsigned OP_W      = 3;
   localparam int unsigned XY_W      = 13;
   localparam int unsigned XYE_W     = XY_W + 1;
   localparam int unsigned PITCH_W   = 14;
   localparam int unsigned FRAME_W   = 17;
   localparam int unsigned COLOR_W   = 32;
   localparam int unsigned COUNT_W   = 17;
   localparam int unsigned STATUS_W  = 2;
   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned CSR_DAT_W = 17;

   // Far corner address math: (y * pitch) + x.
   localparam int unsigned PROD_W = XYE_W + PITCH_W;
   localparam int unsigned FAR_W  = PROD_W + 1;

   // Start address carried in a command, wide enough for the largest store.
   localparam int unsigned CMD_ADDR_W = 24;

   // Depth of the queue between front and back.
   localparam int unsigned CMDQ_DEPTH = 2;

   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_H_RES       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_V_RES       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LINE_PITCH  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WORDS = 3'd3;

   // Register reset values.
   localparam logic [XY_W-1:0]    H_RES_RESET       = 13'd256;
   localparam logic [XY_W-1:0]    V_RES_RESET       = 13'd256;
   localparam logic [PITCH_W-1:0] LINE_PITCH_RESET  = 14'd256;
   localparam logic [FRAME_W-1:0] FRAME_WORDS_RESET = 17'd65536;

   // Operation codes.
   localparam logic [OP_W-1:0] OP_CLEAR_BLACK = 3'd0;
   localparam logic [OP_W-1:0] OP_CLEAR_COLOR = 3'd1;
   localparam logic [OP_W-1:0] OP_REPLACE_BG  = 3'd2;
   localparam logic [OP_W-1:0] OP_DRAW_PIXEL  = 3'd3;
   localparam logic [OP_W-1:0] OP_FILL_RECT   = 3'd4;

   // Result status codes.
   typedef enum logic [STATUS_W-1:0] {
      STATUS_DONE = 2'd0,
      STATUS_POS  = 2'd1,
      STATUS_ADDR = 2'd2
   } status_type;

   // Work kinds handed from front to back.
   typedef enum logic [1:0] {
      KIND_REPORT     = 2'd0,
      KIND_FRAME_FILL = 2'd1,
      KIND_RECOLOR    = 2'd2,
      KIND_RECT       = 2'd3
   } cmd_kind_type;

   // Configuration register file contents.
   typedef struct packed {
      logic [XY_W-1:0]    h_res;
      logic [XY_W-1:0]    v_res;
      logic [PITCH_W-1:0] line_pitch;
      logic [FRAME_W-1:0] frame_words;
   } cfg_type;

   // One classified command. For a rectangle, addr is the far corner and
   // the back end walks toward the near corner.
   typedef struct packed {
      cmd_kind_type          kind;
      status_type            status;
      logic                  set_bg;
      logic [COLOR_W-1:0]    color;
      logic [CMD_ADDR_W-1:0] addr;
      logic [FRAME_W-1:0]    len;
      logic [XY_W-1:0]       cols;
      logic [XY_W-1:0]       rows;
   } cmd_type;

endpackage

@@ hdl/fbf_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fbf_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/fbf_cmdq.sv @@
// ----------------------------------------------------------------------------
// Fill engine command queue
// Short FIFO of classified commands between the front and back ends.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fbf_cmdq
   import fbf_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   input  logic    pop,
   output cmd_type head_cmd,
   output logic    full,
   output logic    empty
);

   localparam int unsigned PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(CMDQ_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(CMDQ_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CMDQ_DEPTH);

   cmd_type          entry_ff [CMDQ_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == FULL_CNT);
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign head_cmd = entry_ff[rd_ptr_ff];

   // Pointer and fill level update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

@@ hdl/fbf_front.sv @@
// ----------------------------------------------------------------------------
// Fill engine front end
// Accepts requests, checks positions and store bounds, and queues one
// classified command per request for the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fbf_front
   import fbf_pkg::*;
#(
   parameter int unsigned STORE_WORDS = DEFAULT_STORE_WORDS
) (
   input  logic               clock,
   input  logic               reset,
   input  cfg_type            cfg,
   input  logic               clearing,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [OP_W-1:0]    req_operation,
   input  logic [XY_W-1:0]    req_pos_x,
   input  logic [XY_W-1:0]    req_pos_y,
   input  logic [XY_W-1:0]    req_rect_width,
   input  logic [XY_W-1:0]    req_rect_height,
   input  logic [COLOR_W-1:0] req_color,
   input  logic               q_full,
   output logic               q_push,
   output cmd_type            q_cmd
);

   localparam logic [FAR_W-1:0] STORE_LIMIT = FAR_W'(STORE_WORDS);

   typedef enum logic [3:0] {
      F_IDLE = 4'b0001,
      F_CALC = 4'b0010,
      F_ADDR = 4'b0100,
      F_PUSH = 4'b1000
   } front_state_type;

   front_state_type state_ff, state_in;

   logic [OP_W-1:0]    op_ff;
   logic [XY_W-1:0]    x_ff, y_ff, w_ff, h_ff;
   logic [COLOR_W-1:0] color_ff;
   logic [XYE_W-1:0]   fx_ff, fy_ff, fx_in, fy_in;
   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic               corner_ok_ff, corner_ok_in;
   logic               far_ok_ff, far_ok_in;
   logic               empty_ff, empty_in;
   cmd_type            cmd_ff, cmd_in;
   logic [FAR_W-1:0]   far_addr;
   logic               addr_ok, frame_ok, accept;

   assign req_stall = (state_ff != F_IDLE) || clearing;
   assign accept    = req_valid && !req_stall;
   assign q_push    = (state_ff == F_PUSH) && !q_full;
   assign q_cmd     = cmd_ff;

   // Far corner, position checks and the row product.
   always_comb begin
      if (op_ff == OP_FILL_RECT) begin
         fx_in = {1'b0, x_ff} + {1'b0, w_ff} - XYE_W'(1);
         fy_in = {1'b0, y_ff} + {1'b0, h_ff} - XYE_W'(1);
      end else begin
         fx_in = {1'b0, x_ff};
         fy_in = {1'b0, y_ff};
      end
      corner_ok_in = (x_ff < cfg.h_res) && (y_ff < cfg.v_res);
      far_ok_in    = (fx_in < {1'b0, cfg.h_res}) && (fy_in < {1'b0, cfg.v_res});
      empty_in     = (w_ff == '0) || (h_ff == '0);
      prod_in      = PROD_W'(fy_in) * PROD_W'(cfg.line_pitch);
   end

   // Store bound checks on the registered product.
   assign far_addr = {1'b0, prod_ff} + FAR_W'(fx_ff);
   assign addr_ok  = (far_addr < STORE_LIMIT);
   assign frame_ok = (FAR_W'(cfg.frame_words) <= STORE_LIMIT);

   // Command classification.
   always_comb begin
      cmd_in        = cmd_ff;
      cmd_in.kind   = KIND_REPORT;
      cmd_in.status = STATUS_DONE;
      cmd_in.set_bg = 1'b0;
      cmd_in.color  = color_ff;
      cmd_in.addr   = CMD_ADDR_W'(far_addr);
      cmd_in.len    = cfg.frame_words;
      cmd_in.cols   = w_ff;
      cmd_in.rows   = h_ff;
      case (op_ff)
         OP_CLEAR_BLACK, OP_CLEAR_COLOR, OP_REPLACE_BG: begin
            if (!frame_ok) begin
               cmd_in.status = STATUS_ADDR;
            end else if (op_ff == OP_CLEAR_BLACK) begin
               cmd_in.kind  = KIND_FRAME_FILL;
               cmd_in.color = '0;
            end else if (op_ff == OP_CLEAR_COLOR) begin
               cmd_in.kind   = KIND_FRAME_FILL;
               cmd_in.set_bg = 1'b1;
            end else begin
               cmd_in.kind   = KIND_RECOLOR;
               cmd_in.set_bg = 1'b1;
            end
         end
         OP_DRAW_PIXEL: begin
            if (!corner_ok_ff) begin
               cmd_in.status = STATUS_POS;
            end else if (!addr_ok) begin
               cmd_in.status = STATUS_ADDR;
            end else begin
               cmd_in.kind = KIND_RECT;
               cmd_in.cols = XY_W'(1);
               cmd_in.rows = XY_W'(1);
            end
         end
         OP_FILL_RECT: begin
            if (!corner_ok_ff) begin
               cmd_in.status = STATUS_POS;
            end else if (empty_ff) begin
               cmd_in.status = STATUS_DONE;
            end else if (!far_ok_ff) begin
               cmd_in.status = STATUS_POS;
            end else if (!addr_ok) begin
               cmd_in.status = STATUS_ADDR;
            end else begin
               cmd_in.kind = KIND_RECT;
            end
         end
         default: begin
            cmd_in.status = STATUS_DONE;
         end
      endcase
   end

   // Sequencer: accept, compute, classify, queue.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         F_IDLE: begin
            if (accept) begin
               state_in = F_CALC;
            end
         end
         F_CALC: begin
            state_in = F_ADDR;
         end
         F_ADDR: begin
            state_in = F_PUSH;
         end
         F_PUSH: begin
            if (!q_full) begin
               state_in = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Request capture.
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff    <= req_operation;
         x_ff     <= req_pos_x;
         y_ff     <= req_pos_y;
         w_ff     <= req_rect_width;
         h_ff     <= req_rect_height;
         color_ff <= req_color;
      end
   end

   // Check results and product.
   always_ff @(posedge clock) begin
      if (state_ff == F_CALC) begin
         fx_ff        <= fx_in;
         fy_ff        <= fy_in;
         prod_ff      <= prod_in;
         corner_ok_ff <= corner_ok_in;
         far_ok_ff    <= far_ok_in;
         empty_ff     <= empty_in;
      end
   end

   // Classified command.
   always_ff @(posedge clock) begin
      if (state_ff == F_ADDR) begin
         cmd_ff <= cmd_in;
      end
   end

endmodule

@@ hdl/fbf_back.sv @@
// ----------------------------------------------------------------------------
// Fill engine back end
// Owns the pixel store and the background color, carries out queued
// commands one store word per cycle, and holds the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fbf_back
   import fbf_pkg::*;
#(
   parameter int unsigned STORE_WORDS = DEFAULT_STORE_WORDS
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [PITCH_W-1:0]  line_pitch,
   input  logic                q_empty,
   input  cmd_type             q_cmd,
   output logic                q_pop,
   output logic                clearing,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [COUNT_W-1:0]  rsp_pixels_written
);

   localparam int unsigned ADDR_W = $clog2(STORE_WORDS);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_WORDS - 1);

   typedef enum logic [5:0] {
      B_CLEAR   = 6'b000001,
      B_IDLE    = 6'b000010,
      B_FILL    = 6'b000100,
      B_RECOLOR = 6'b001000,
      B_DRAIN   = 6'b010000,
      B_RECT    = 6'b100000
   } back_state_type;

   // The result hand-off shares the idle state; this alias names it.
   localparam back_state_type B_DONE_UNUSED = B_IDLE;

   back_state_type state_ff, state_in;
   logic           done_ff, done_in;

   cmd_type            cmd_ff, cmd_in;
   logic [ADDR_W-1:0]  addr_ff, addr_in;
   logic [ADDR_W-1:0]  row_base_ff, row_base_in;
   logic [FRAME_W-1:0] remain_ff, remain_in;
   logic [XY_W-1:0]    col_left_ff, col_left_in;
   logic [XY_W-1:0]    row_left_ff, row_left_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               pend_valid_ff, pend_valid_in;
   logic [ADDR_W-1:0]  pend_addr_ff, pend_addr_in;
   logic [COLOR_W-1:0] bg_ff, bg_in;
   logic               rsp_valid_ff, rsp_valid_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic [COUNT_W-1:0] rsp_count_ff, rsp_count_in;

   logic               wr_en, rd_en, hit, count_inc, out_free, load_rsp;
   logic [ADDR_W-1:0]  wr_addr, pitch_step, start_addr;
   logic [COLOR_W-1:0] wr_data, rd_data;

   assign clearing           = (state_ff == B_CLEAR);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_pixels_written = rsp_count_ff;

   assign pitch_step = ADDR_W'(line_pitch);
   assign start_addr = q_cmd.addr[ADDR_W-1:0];
   assign q_pop      = (state_ff == B_IDLE) && !done_ff && !q_empty;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign load_rsp   = (state_ff == B_IDLE) && done_ff && out_free;

   // Recolor compare: the word read last cycle against the background.
   assign hit = pend_valid_ff && (rd_data == bg_ff);

   // Store port selection.
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = addr_ff;
      wr_data = cmd_ff.color;
      case (state_ff)
         B_CLEAR: begin
            wr_en   = 1'b1;
            wr_data = '0;
         end
         B_FILL, B_RECT: begin
            wr_en = 1'b1;
         end
         B_RECOLOR, B_DRAIN: begin
            wr_en   = hit;
            wr_addr = pend_addr_ff;
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   assign rd_en     = (state_ff == B_RECOLOR);
   assign count_inc = (state_ff == B_FILL) || (state_ff == B_RECT) || hit;

   fbf_ram #(
      .WIDTH (COLOR_W),
      .DEPTH (STORE_WORDS)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (addr_ff),
      .rd_data (rd_data)
   );

   // Walk sequencer.
   always_comb begin
      state_in      = state_ff;
      done_in       = done_ff;
      cmd_in        = cmd_ff;
      addr_in       = addr_ff;
      row_base_in   = row_base_ff;
      remain_in     = remain_ff;
      col_left_in   = col_left_ff;
      row_left_in   = row_left_ff;
      count_in      = count_ff;
      pend_valid_in = 1'b0;
      pend_addr_in  = pend_addr_ff;
      bg_in         = bg_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;

      // Saturating count of words written.
      if (count_inc && (count_ff != COUNT_MAX)) begin
         count_in = count_ff + 1'b1;
      end

      case (state_ff)
         B_CLEAR: begin
            addr_in = addr_ff + 1'b1;
            if (addr_ff == LAST_ADDR) begin
               state_in = B_IDLE;
            end
         end
         B_IDLE: begin
            if (done_ff) begin
               // Hand the result over once the output register is free.
               if (out_free) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = cmd_ff.status;
                  rsp_count_in  = count_ff;
                  if (cmd_ff.set_bg) begin
                     bg_in = cmd_ff.color;
                  end
                  done_in = 1'b0;
               end
            end else if (!q_empty) begin
               cmd_in      = q_cmd;
               count_in    = '0;
               remain_in   = q_cmd.len;
               col_left_in = q_cmd.cols;
               row_left_in = q_cmd.rows;
               case (q_cmd.kind)
                  KIND_FRAME_FILL: begin
                     addr_in = '0;
                     if (q_cmd.len == '0) begin
                        done_in = 1'b1;
                     end else begin
                        state_in = B_FILL;
                     end
                  end
                  KIND_RECOLOR: begin
                     addr_in = '0;
                     if (q_cmd.len == '0) begin
                        done_in = 1'b1;
                     end else begin
                        state_in = B_RECOLOR;
                     end
                  end
                  KIND_RECT: begin
                     addr_in     = start_addr;
                     row_base_in = start_addr;
                     state_in    = B_RECT;
                  end
                  default: begin
                     done_in = 1'b1;
                  end
               endcase
            end
         end
         B_FILL: begin
            addr_in   = addr_ff + 1'b1;
            remain_in = remain_ff - 1'b1;
            if (remain_ff == FRAME_W'(1)) begin
               state_in = B_IDLE;
               done_in  = 1'b1;
            end
         end
         B_RECOLOR: begin
            pend_valid_in = 1'b1;
            pend_addr_in  = addr_ff;
            addr_in       = addr_ff + 1'b1;
            remain_in     = remain_ff - 1'b1;
            if (remain_ff == FRAME_W'(1)) begin
               state_in = B_DRAIN;
            end
         end
         B_DRAIN: begin
            state_in = B_IDLE;
            done_in  = 1'b1;
         end
         B_RECT: begin
            // Walk from the far corner back toward the near corner.
            if (col_left_ff == XY_W'(1)) begin
               if (row_left_ff == XY_W'(1)) begin
                  state_in = B_IDLE;
                  done_in  = 1'b1;
               end else begin
                  row_base_in = row_base_ff - pitch_step;
                  addr_in     = row_base_ff - pitch_step;
                  col_left_in = cmd_ff.cols;
                  row_left_in = row_left_ff - 1'b1;
               end
            end else begin
               addr_in     = addr_ff - 1'b1;
               col_left_in = col_left_ff - 1'b1;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= B_CLEAR;
         done_ff       <= 1'b0;
         addr_ff       <= '0;
         pend_valid_ff <= 1'b0;
         bg_ff         <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         done_ff       <= done_in;
         addr_ff       <= addr_in;
         pend_valid_ff <= pend_valid_in;
         bg_ff         <= bg_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Walk payload and result payload.
   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      row_base_ff  <= row_base_in;
      remain_ff    <= remain_in;
      col_left_ff  <= col_left_in;
      row_left_ff  <= row_left_in;
      count_ff     <= count_in;
      pend_addr_ff <= pend_addr_in;
      if (load_rsp) begin
         rsp_status_ff <= rsp_status_in;
         rsp_count_ff  <= rsp_count_in;
      end
   end

   // The result hand-off shares the idle state; keep the alias referenced.
   logic idle_alias;
   assign idle_alias = (B_DONE_UNUSED == B_IDLE);

endmodule

@@ hdl/framebuffer_fill_engine_unit.sv @@
// ----------------------------------------------------------------------------
// Framebuffer fill engine
// Clears, recolors and fills rectangles in an internal pixel store.
// ----------------------------------------------------------------------------
// After reset the engine zeroes its store, one word per cycle, and holds
// req_stall high meanwhile; register writes are taken throughout. Each
// request then passes a front end that captures, checks, classifies and
// queues it, and the back end writes the store one word per cycle through
// its single write port: a clear writes frame_words words, a recolor those
// that match the background, a rectangle width times height words, a pixel
// one word and a rejected request none. Every request returns exactly one
// response with a status and the number of words written.
`timescale 1ns / 1ps

module framebuffer_fill_engine_unit
   import fbf_pkg::*;
#(
   parameter int unsigned STORE_WORDS = DEFAULT_STORE_WORDS
) (
   input  logic                 clock,
   input  logic                 reset,
   // Request channel.
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [OP_W-1:0]      req_operation,
   input  logic [XY_W-1:0]      req_pos_x,
   input  logic [XY_W-1:0]      req_pos_y,
   input  logic [XY_W-1:0]      req_rect_width,
   input  logic [XY_W-1:0]      req_rect_height,
   input  logic [COLOR_W-1:0]   req_color,
   // Response channel.
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [STATUS_W-1:0]  rsp_status,
   output logic [COUNT_W-1:0]   rsp_pixels_written,
   // Register write channel.
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_data
);

   cfg_type cfg_ff, cfg_in;
   cmd_type push_cmd, head_cmd;
   logic    q_push, q_pop, q_full, q_empty, clearing;

   assign csr_ready = 1'b1;

   // Register file writes.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_H_RES:       cfg_in.h_res       = csr_data[XY_W-1:0];
            CSR_V_RES:       cfg_in.v_res       = csr_data[XY_W-1:0];
            CSR_LINE_PITCH:  cfg_in.line_pitch  = csr_data[PITCH_W-1:0];
            CSR_FRAME_WORDS: cfg_in.frame_words = csr_data[FRAME_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.h_res       <= H_RES_RESET;
         cfg_ff.v_res       <= V_RES_RESET;
         cfg_ff.line_pitch  <= LINE_PITCH_RESET;
         cfg_ff.frame_words <= FRAME_WORDS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   fbf_front #(
      .STORE_WORDS (STORE_WORDS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .clearing        (clearing),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_operation   (req_operation),
      .req_pos_x       (req_pos_x),
      .req_pos_y       (req_pos_y),
      .req_rect_width  (req_rect_width),
      .req_rect_height (req_rect_height),
      .req_color       (req_color),
      .q_full          (q_full),
      .q_push          (q_push),
      .q_cmd           (push_cmd)
   );

   fbf_cmdq u_cmdq (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (push_cmd),
      .pop      (q_pop),
      .head_cmd (head_cmd),
      .full     (q_full),
      .empty    (q_empty)
   );

   fbf_back #(
      .STORE_WORDS (STORE_WORDS)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .line_pitch         (cfg_ff.line_pitch),
      .q_empty            (q_empty),
      .q_cmd              (head_cmd),
      .q_pop              (q_pop),
      .clearing           (clearing),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_pixels_written (rsp_pixels_written)
   );

endmodule

@@ hdl/fbf_checker.sv @@
// ----------------------------------------------------------------------------
// Fill engine checker
// Port-level assertions on the response channel and the reset clear.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fbf_checker
   import fbf_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_stall,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input logic [STATUS_W-1:0]  rsp_status,
   input logic [COUNT_W-1:0]   rsp_pixels_written
);

   // Only the three defined status codes are ever reported.
   `FBF_ASSERT_IMP(a_status_code, clock, reset, rsp_valid, (rsp_status == STATUS_DONE) || (rsp_status == STATUS_POS) || (rsp_status == STATUS_ADDR), "undefined response status")

   // A rejected request writes nothing.
   `FBF_ASSERT_IMP(a_reject_no_write, clock, reset, rsp_valid && (rsp_status != STATUS_DONE), rsp_pixels_written == '0, "rejected request reports written words")

   // A stalled response holds.
   `FBF_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_status) && $stable(rsp_pixels_written), "stalled response changed")

   // When reset is released, the store clear is holding req_stall high.
   `FBF_ASSERT_IMP(a_clear_stall, clock, reset, $past(reset), req_stall, "request taken during the store clear")

endmodule

bind framebuffer_fill_engine_unit fbf_checker u_fbf_checker (.*);
